### rtl/nearest_centroid_classifier_unit_assert.svh
// Assertion helpers for the nearest centroid classifier.
`ifndef NEAREST_CENTROID_CLASSIFIER_UNIT_ASSERT_SVH
`define NEAREST_CENTROID_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock outside reset.
`define NCC_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ncc assertion failed");

// Next-cycle implication.
`define NCC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ncc assertion failed");

`endif

### rtl/ncc_pkg.sv
package ncc_pkg;

   localparam int MAX_CLUSTERS = 16;
   localparam int MAX_FIELDS   = 16;

   localparam int CLUSTER_AW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int FIELD_AW    = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
   localparam int TREE_LEVELS = $clog2(MAX_CLUSTERS);
   localparam int TREE_SIZE   = 1 << TREE_LEVELS;

   localparam int VALUE_W  = 32;
   localparam int WEIGHT_W = 24;
   localparam int SUM_W    = 56;
   localparam int COUNT_W  = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // configuration register indexes
   localparam logic [1:0] CSR_NULL_REJECTS  = 2'd0;
   localparam logic [1:0] CSR_CLUSTER_COUNT = 2'd1;
   localparam logic [1:0] CSR_FIELD_COUNT   = 2'd2;

   localparam logic [4:0] CLUSTER_COUNT_RESET = 5'd16;
   localparam logic [4:0] FIELD_COUNT_RESET   = 5'd16;

   typedef enum logic [1:0] {
      ACTION_CENTROID = 2'd0,
      ACTION_TABLE    = 2'd1,
      ACTION_RECORD   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      STATUS_FOUND       = 2'd0,
      STATUS_NULL_REJECT = 2'd1,
      STATUS_ALL_NULL    = 2'd2,
      STATUS_NO_FIELD    = 2'd3
   } status_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  average;
      logic [WEIGHT_W-1:0] weight;
      logic                skip;
   } field_entry_type;

   localparam int TABLE_W = $bits(field_entry_type);

endpackage

### rtl/ncc_ram.sv
module ncc_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              write_enable,
   input  logic [ADDR_W-1:0] write_address,
   input  logic [WIDTH-1:0]  write_data,
   input  logic              read_enable,
   input  logic [ADDR_W-1:0] read_address,
   output logic [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

### rtl/nearest_centroid_classifier_unit.sv
// Nearest centroid classifier, range-normalized L1 distance over streamed fields.
// Throughput: one request per clock; input stalls only while a finished response
// meets a stalled one in the response register.
// A request with last set reaches its response through stages 1 to 3, the tree
// levels and the response register; the minimum search is a registered tree.
// Reset (synchronous, active high) clears accumulators, counts, valids and config.
`include "nearest_centroid_classifier_unit_assert.svh"

module nearest_centroid_classifier_unit (
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [4:0]          csr_write_data,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic [3:0]          req_cluster_index,
   input  logic [3:0]          req_field_index,
   input  logic signed [31:0]  req_value,
   input  logic [23:0]         req_inv_range,
   input  logic                req_zero_range,
   input  logic                req_is_null,
   input  logic                req_last,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_nearest_cluster,
   output logic [1:0]          rsp_status
);

   localparam int NC = ncc_pkg::MAX_CLUSTERS;
   localparam int NT = ncc_pkg::TREE_SIZE;
   localparam int NL = ncc_pkg::TREE_LEVELS;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic       null_rejects_ff;
   logic [4:0] cluster_count_ff;
   logic [4:0] field_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         null_rejects_ff  <= 1'b0;
         cluster_count_ff <= ncc_pkg::CLUSTER_COUNT_RESET;
         field_count_ff   <= ncc_pkg::FIELD_COUNT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            ncc_pkg::CSR_NULL_REJECTS:  null_rejects_ff  <= csr_write_data[0];
            ncc_pkg::CSR_CLUSTER_COUNT: cluster_count_ff <= csr_write_data;
            ncc_pkg::CSR_FIELD_COUNT:   field_count_ff   <= csr_write_data;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Flow control: the whole pipe moves together. It freezes only when a
   // finished response leaves the tree while the response register is full
   // and stalled; otherwise bubbles and records keep flowing behind it.
   // ---------------------------------------------------------------------
   logic rsp_valid_ff;
   logic rsp_hold;
   logic t_valid_ff [NL+1];
   logic advance;
   logic req_accept;

   assign rsp_hold   = rsp_valid_ff && rsp_stall;
   assign advance    = !(rsp_hold && t_valid_ff[NL]);
   assign req_stall  = !advance;
   assign req_accept = req_valid && advance;

   logic is_centroid_wr;
   logic is_table_wr;
   logic is_record;
   logic field_in_table;
   logic field_in_use;

   assign is_centroid_wr = (req_action == ncc_pkg::ACTION_CENTROID);
   assign is_table_wr    = (req_action == ncc_pkg::ACTION_TABLE);
   assign is_record      = (req_action == ncc_pkg::ACTION_RECORD);
   assign field_in_table = int'(req_field_index) < ncc_pkg::MAX_FIELDS;
   // below min(field_count, MAX_FIELDS)
   assign field_in_use   = field_in_table && (int'(req_field_index) < int'(field_count_ff));

   logic [ncc_pkg::FIELD_AW-1:0] field_addr;
   assign field_addr = ncc_pkg::FIELD_AW'(req_field_index);

   // ---------------------------------------------------------------------
   // Storage: one centroid bank per cluster (indexed by field) so that all
   // clusters are read in parallel, plus the per-field table.
   // Writes land at the accept edge; a later request reads at a later edge.
   // ---------------------------------------------------------------------
   logic [ncc_pkg::VALUE_W-1:0] centroid_rdata [NC];
   logic [ncc_pkg::TABLE_W-1:0] table_rdata;

   ncc_pkg::field_entry_type table_wdata;
   assign table_wdata.average = req_value;
   assign table_wdata.weight  = req_inv_range;
   assign table_wdata.skip    = req_zero_range;

   for (genvar c = 0; c < NC; c++) begin : g_bank
      logic bank_we;
      assign bank_we = req_accept && is_centroid_wr && field_in_table
                       && (int'(req_cluster_index) == c);

      ncc_ram #(
         .WIDTH (ncc_pkg::VALUE_W),
         .DEPTH (ncc_pkg::MAX_FIELDS)
      ) u_centroid_ram (
         .clock         (clock),
         .write_enable  (bank_we),
         .write_address (field_addr),
         .write_data    (req_value),
         .read_enable   (req_accept),
         .read_address  (field_addr),
         .read_data     (centroid_rdata[c])
      );
   end

   ncc_ram #(
      .WIDTH (ncc_pkg::TABLE_W),
      .DEPTH (ncc_pkg::MAX_FIELDS)
   ) u_table_ram (
      .clock         (clock),
      .write_enable  (req_accept && is_table_wr && field_in_table),
      .write_address (field_addr),
      .write_data    (table_wdata),
      .read_enable   (req_accept),
      .read_address  (field_addr),
      .read_data     (table_rdata)
   );

   // ---------------------------------------------------------------------
   // Stage 1: request registered alongside the memory read data
   // ---------------------------------------------------------------------
   logic                        s1_valid_ff;
   logic                        s1_in_use_ff;
   logic [ncc_pkg::VALUE_W-1:0] s1_value_ff;
   logic                        s1_is_null_ff;
   logic                        s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_accept && is_record;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_in_use_ff  <= field_in_use;
         s1_value_ff   <= req_value;
         s1_is_null_ff <= req_is_null;
         s1_last_ff    <= req_last;
      end
   end

   // absolute difference per cluster; a null field takes the field average
   ncc_pkg::field_entry_type     s1_entry;
   logic                         s1_used;
   logic [ncc_pkg::VALUE_W-1:0]  s1_point;
   logic signed [ncc_pkg::VALUE_W:0] s1_diff [NC];
   logic [ncc_pkg::VALUE_W-1:0]  s1_dist [NC];

   assign s1_entry = ncc_pkg::field_entry_type'(table_rdata);
   assign s1_used  = s1_valid_ff && s1_in_use_ff && !s1_entry.skip;
   assign s1_point = s1_is_null_ff ? s1_entry.average : s1_value_ff;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         s1_diff[c] = $signed({centroid_rdata[c][ncc_pkg::VALUE_W-1], centroid_rdata[c]})
                    - $signed({s1_point[ncc_pkg::VALUE_W-1], s1_point});
         // |diff| is at most 2^32-1
         s1_dist[c] = s1_diff[c][ncc_pkg::VALUE_W] ? ncc_pkg::VALUE_W'(-s1_diff[c])
                                                   : s1_diff[c][ncc_pkg::VALUE_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: distances registered, then weighted by the reciprocal range
   // ---------------------------------------------------------------------
   logic                         s2_valid_ff;
   logic                         s2_used_ff;
   logic                         s2_null_ff;
   logic                         s2_last_ff;
   logic [ncc_pkg::WEIGHT_W-1:0] s2_weight_ff;
   logic [ncc_pkg::VALUE_W-1:0]  s2_dist_ff [NC];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_used_ff   <= s1_used;
         s2_null_ff   <= s1_used && s1_is_null_ff;
         s2_last_ff   <= s1_last_ff;
         s2_weight_ff <= s1_entry.weight;
         for (int c = 0; c < NC; c++) begin
            s2_dist_ff[c] <= s1_dist[c];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: products registered (Q16.40, exact, below 2^56)
   // ---------------------------------------------------------------------
   logic                      s3_valid_ff;
   logic                      s3_used_ff;
   logic                      s3_null_ff;
   logic                      s3_last_ff;
   logic [ncc_pkg::SUM_W-1:0] s3_prod_ff [NC];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_used_ff <= s2_used_ff;
         s3_null_ff <= s2_null_ff;
         s3_last_ff <= s2_last_ff;
         for (int c = 0; c < NC; c++) begin
            s3_prod_ff[c] <= s2_used_ff
                           ? ncc_pkg::SUM_W'(ncc_pkg::SUM_W'(s2_dist_ff[c])
                                             * ncc_pkg::SUM_W'(s2_weight_ff))
                           : '0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Accumulate: saturating add per cluster, used/null counts, decision
   // ---------------------------------------------------------------------
   logic [ncc_pkg::SUM_W-1:0]   acc_ff [NC];
   logic [ncc_pkg::SUM_W-1:0]   acc_in [NC];
   logic [ncc_pkg::SUM_W:0]     acc_wide [NC];
   logic [ncc_pkg::SUM_W-1:0]   acc_next [NT];   // padded to the tree width
   logic [ncc_pkg::COUNT_W-1:0] used_count_ff;
   logic [ncc_pkg::COUNT_W-1:0] used_count_in;
   logic [ncc_pkg::COUNT_W-1:0] used_count_next;
   logic [ncc_pkg::COUNT_W-1:0] null_count_ff;
   logic [ncc_pkg::COUNT_W-1:0] null_count_in;
   logic [ncc_pkg::COUNT_W-1:0] null_count_next;
   logic                        null_hit_ff;
   logic                        null_hit_in;
   logic                        null_hit_next;
   logic                        record_end;
   ncc_pkg::status_type         s3_status;

   assign record_end = s3_valid_ff && s3_last_ff;

   always_comb begin
      for (int c = 0; c < NT; c++) begin
         acc_next[c] = '0;
      end
      for (int c = 0; c < NC; c++) begin
         acc_wide[c] = {1'b0, acc_ff[c]} + {1'b0, s3_prod_ff[c]};
         acc_next[c] = (s3_valid_ff && s3_used_ff)
                     ? (acc_wide[c][ncc_pkg::SUM_W] ? '1 : acc_wide[c][ncc_pkg::SUM_W-1:0])
                     : acc_ff[c];
         acc_in[c]   = record_end ? '0 : acc_next[c];
      end

      used_count_next = used_count_ff;
      null_count_next = null_count_ff;
      null_hit_next   = null_hit_ff;
      if (s3_valid_ff && s3_used_ff && used_count_ff != ncc_pkg::COUNT_MAX) begin
         used_count_next = used_count_ff + 1'b1;
      end
      if (s3_valid_ff && s3_null_ff) begin
         null_hit_next = 1'b1;
         if (null_count_ff != ncc_pkg::COUNT_MAX) begin
            null_count_next = null_count_ff + 1'b1;
         end
      end

      used_count_in = record_end ? '0 : used_count_next;
      null_count_in = record_end ? '0 : null_count_next;
      null_hit_in   = record_end ? 1'b0 : null_hit_next;

      // decision order: reject, all null, nothing usable, found
      if (null_rejects_ff && null_hit_next) begin
         s3_status = ncc_pkg::STATUS_NULL_REJECT;
      end else if (null_count_next == field_count_ff) begin
         s3_status = ncc_pkg::STATUS_ALL_NULL;
      end else if (used_count_next == '0 || cluster_count_ff == '0) begin
         s3_status = ncc_pkg::STATUS_NO_FIELD;
      end else begin
         s3_status = ncc_pkg::STATUS_FOUND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NC; c++) begin
            acc_ff[c] <= '0;
         end
         used_count_ff <= '0;
         null_count_ff <= '0;
         null_hit_ff   <= 1'b0;
      end else if (advance) begin
         for (int c = 0; c < NC; c++) begin
            acc_ff[c] <= acc_in[c];
         end
         used_count_ff <= used_count_in;
         null_count_ff <= null_count_in;
         null_hit_ff   <= null_hit_in;
      end
   end

   // ---------------------------------------------------------------------
   // Minimum search: registered binary tree. Level 0 snapshots the final sums
   // of a record; each level halves the candidates. Ties keep the left (lower
   // cluster) entry; clusters at or above cluster_count never win.
   // ---------------------------------------------------------------------
   ncc_pkg::status_type            t_status_ff [NL+1];
   logic [NT-1:0]                  t_ok_ff     [NL+1];
   logic [ncc_pkg::SUM_W-1:0]      t_sum_ff    [NL+1][NT];
   logic [ncc_pkg::CLUSTER_AW-1:0] t_idx_ff    [NL+1][NT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l <= NL; l++) begin
            t_valid_ff[l] <= 1'b0;
         end
      end else if (advance) begin
         t_valid_ff[0] <= record_end;
         for (int l = 0; l < NL; l++) begin
            t_valid_ff[l+1] <= t_valid_ff[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t_status_ff[0] <= s3_status;
         for (int j = 0; j < NT; j++) begin
            t_sum_ff[0][j] <= acc_next[j];
            t_idx_ff[0][j] <= ncc_pkg::CLUSTER_AW'(j);
            t_ok_ff[0][j]  <= (j < NC) && (j < int'(cluster_count_ff));
         end
         for (int l = 0; l < NL; l++) begin
            t_status_ff[l+1] <= t_status_ff[l];
            for (int j = 0; j < (NT >> (l + 1)); j++) begin
               if (t_ok_ff[l][2*j+1]
                   && (!t_ok_ff[l][2*j] || t_sum_ff[l][2*j+1] < t_sum_ff[l][2*j])) begin
                  t_sum_ff[l+1][j] <= t_sum_ff[l][2*j+1];
                  t_idx_ff[l+1][j] <= t_idx_ff[l][2*j+1];
               end else begin
                  t_sum_ff[l+1][j] <= t_sum_ff[l][2*j];
                  t_idx_ff[l+1][j] <= t_idx_ff[l][2*j];
               end
               t_ok_ff[l+1][j] <= t_ok_ff[l][2*j] || t_ok_ff[l][2*j+1];
            end
            for (int j = (NT >> (l + 1)); j < NT; j++) begin
               t_sum_ff[l+1][j] <= '0;
               t_idx_ff[l+1][j] <= '0;
               t_ok_ff[l+1][j]  <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response register: holds while stalled, refills as soon as taken
   // ---------------------------------------------------------------------
   logic [3:0]          rsp_cluster_ff;
   ncc_pkg::status_type rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_hold) begin
         rsp_valid_ff <= t_valid_ff[NL];
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_hold) begin
         rsp_status_ff  <= t_status_ff[NL];
         // cluster reads zero unless a cluster was found
         rsp_cluster_ff <= (t_status_ff[NL] == ncc_pkg::STATUS_FOUND)
                         ? 4'(t_idx_ff[NL][0]) : 4'd0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_nearest_cluster = rsp_cluster_ff;
   assign rsp_status          = rsp_status_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `NCC_ASSERT_IMPLIES(a_no_cluster_unless_found,
      rsp_valid && rsp_status != ncc_pkg::STATUS_FOUND, rsp_nearest_cluster == 4'd0)
   `NCC_ASSERT_NEXT(a_record_end_clears, advance && record_end,
      used_count_ff == '0 && null_count_ff == '0 && !null_hit_ff)
   `NCC_ASSERT_NEXT(a_record_end_enters_tree, advance && record_end, t_valid_ff[0])
   `NCC_ASSERT_IMPLIES(a_nulls_within_used, 1'b1, null_count_ff <= used_count_ff)
   `NCC_ASSERT_IMPLIES(a_null_hit_counted, null_hit_ff, null_count_ff != '0)

endmodule
